### sv/pfn_pkg.sv
// Shared types, constants and helpers for the fractal gradient-noise block.
package pfn_pkg;

  localparam int MAX_OCTAVES = 16;
  localparam int TABLE_SIZE  = 256;
  localparam int OCT_W       = $clog2(MAX_OCTAVES);
  localparam int CNT_W       = $clog2(MAX_OCTAVES + 1);
  localparam int IDX_W       = $clog2(TABLE_SIZE);

  // Configuration register indexes
  localparam logic REG_OCTAVE_COUNT   = 1'b0;
  localparam logic REG_BASE_FREQUENCY = 1'b1;

  // Datapath step codes
  localparam logic [3:0] OP_IDLE = 4'd0;
  localparam logic [3:0] OP_PX   = 4'd1;
  localparam logic [3:0] OP_PY   = 4'd2;
  localparam logic [3:0] OP_O0   = 4'd3;
  localparam logic [3:0] OP_O1   = 4'd4;
  localparam logic [3:0] OP_O2   = 4'd5;
  localparam logic [3:0] OP_O3   = 4'd6;
  localparam logic [3:0] OP_O4   = 4'd7;
  localparam logic [3:0] OP_O5   = 4'd8;
  localparam logic [3:0] OP_O6   = 4'd9;
  localparam logic [3:0] OP_O7   = 4'd10;
  localparam logic [3:0] OP_O8   = 4'd11;
  localparam logic [3:0] OP_O9   = 4'd12;
  localparam logic [3:0] OP_O10  = 4'd13;
  localparam logic [3:0] OP_DONE = 4'd14;

  typedef struct packed {
    logic [3:0]       op;
    logic             start;
    logic             load_wr;
    logic             init_wr;
    logic [IDX_W-1:0] init_addr;
    logic             out_load;
  } pfn_cmd_t;

  typedef struct packed {
    logic oct_zero;
    logic oct_last;
  } pfn_stat_t;

  // Classic permutation loaded into the table after reset
  localparam logic [7:0] RESET_PERM [TABLE_SIZE] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180};

  // Dot of one of eight gradient directions with a corner offset
  function automatic logic signed [17:0] grad_dot(input logic [2:0] h,
                                                  input logic signed [16:0] dx,
                                                  input logic signed [16:0] dy);
    logic signed [17:0] ex;
    logic signed [17:0] ey;
    ex = {dx[16], dx};
    ey = {dy[16], dy};
    case (h)
      3'd0:    grad_dot = ex + ey;
      3'd1:    grad_dot = ex;
      3'd2:    grad_dot = ex - ey;
      3'd3:    grad_dot = -ey;
      3'd4:    grad_dot = -ex - ey;
      3'd5:    grad_dot = -ex;
      3'd6:    grad_dot = ey - ex;
      default: grad_dot = ey;
    endcase
  endfunction

endpackage

### sv/pfn_ctrl.sv
// Sequencer for table fill, point evaluation octave by octave, and result hand-off.
module pfn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_mode,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  pfn_pkg::pfn_stat_t  stat,
  output pfn_pkg::pfn_cmd_t   cmd
);

  localparam logic [4:0] S_INIT = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_PX   = 5'd2;
  localparam logic [4:0] S_PY   = 5'd3;
  localparam logic [4:0] S_O0   = 5'd4;
  localparam logic [4:0] S_O1   = 5'd5;
  localparam logic [4:0] S_O2   = 5'd6;
  localparam logic [4:0] S_O3   = 5'd7;
  localparam logic [4:0] S_O4   = 5'd8;
  localparam logic [4:0] S_O5   = 5'd9;
  localparam logic [4:0] S_O6   = 5'd10;
  localparam logic [4:0] S_O7   = 5'd11;
  localparam logic [4:0] S_O8   = 5'd12;
  localparam logic [4:0] S_O9   = 5'd13;
  localparam logic [4:0] S_O10  = 5'd14;
  localparam logic [4:0] S_DONE = 5'd15;

  logic [4:0]                state_r, state_nxt;
  logic [pfn_pkg::IDX_W-1:0] fill_r, fill_nxt;
  logic                      oval_r, oval_nxt;
  logic                      acc;
  logic                      load;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;
  assign acc        = in_tvalid && in_tready;
  assign load       = (state_r == S_DONE) && (!oval_r || out_tready);

  // Next state and step selection
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cmd           = '0;
    cmd.op        = pfn_pkg::OP_IDLE;
    cmd.init_addr = fill_r;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        fill_nxt    = fill_r + 1'b1;
        if (fill_r == {pfn_pkg::IDX_W{1'b1}}) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (in_mode) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_PX;
          end
        end
      end
      S_PX: begin cmd.op = pfn_pkg::OP_PX; state_nxt = S_PY; end
      S_PY: begin
        cmd.op    = pfn_pkg::OP_PY;
        state_nxt = stat.oct_zero ? S_DONE : S_O0;
      end
      S_O0: begin cmd.op = pfn_pkg::OP_O0; state_nxt = S_O1; end
      S_O1: begin cmd.op = pfn_pkg::OP_O1; state_nxt = S_O2; end
      S_O2: begin cmd.op = pfn_pkg::OP_O2; state_nxt = S_O3; end
      S_O3: begin cmd.op = pfn_pkg::OP_O3; state_nxt = S_O4; end
      S_O4: begin cmd.op = pfn_pkg::OP_O4; state_nxt = S_O5; end
      S_O5: begin cmd.op = pfn_pkg::OP_O5; state_nxt = S_O6; end
      S_O6: begin cmd.op = pfn_pkg::OP_O6; state_nxt = S_O7; end
      S_O7: begin cmd.op = pfn_pkg::OP_O7; state_nxt = S_O8; end
      S_O8: begin cmd.op = pfn_pkg::OP_O8; state_nxt = S_O9; end
      S_O9: begin cmd.op = pfn_pkg::OP_O9; state_nxt = S_O10; end
      S_O10: begin
        cmd.op    = pfn_pkg::OP_O10;
        state_nxt = stat.oct_last ? S_DONE : S_O0;
      end
      S_DONE: begin
        cmd.op       = pfn_pkg::OP_DONE;
        cmd.out_load = load;
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // Hold the result flag until the beat is taken
  always_comb begin
    oval_nxt = oval_r;
    if (load) oval_nxt = 1'b1;
    else if (out_tready) oval_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      fill_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

### sv/pfn_dp.sv
// Datapath: registers, permutation memory, shared multiplier and octave accumulator.
module pfn_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic [31:0]        x_in,
  input  logic [31:0]        y_in,
  input  logic [7:0]         tidx_in,
  input  logic [7:0]         tval_in,
  input  pfn_pkg::pfn_cmd_t  cmd,
  output pfn_pkg::pfn_stat_t stat,
  output logic [19:0]        noise_value
);

  logic [7:0] mem [pfn_pkg::TABLE_SIZE];

  logic [4:0]                oc_r;
  logic [23:0]               bf_r;
  logic [31:0]               x_r, y_r;
  logic [pfn_pkg::CNT_W-1:0] n_r;
  logic [pfn_pkg::OCT_W-1:0] k_r;
  logic [55:0]               px_r, py_r;
  logic [7:0]                cx_r, cy_r, pa_r, pb_r, rd_r;
  logic [15:0]               fx_r, fy_r, t3_r;
  logic [31:0]               f2_r;
  logic [20:0]               inner_r;
  logic [16:0]               u_r, v_r;
  logic signed [17:0]        dbl_r, dbr_r, dtl_r, dtr_r, lo_r, hi_r, noct_r;
  logic signed [23:0]        sum_r;
  logic [19:0]               out_r;

  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod;
  logic signed [57:0] prod_sh;
  logic [55:0]        shx, shy;
  logic [7:0]         rd_addr;
  logic [15:0]        fsel;
  logic [37:0]        inner_w;
  logic signed [18:0] diff;
  logic signed [16:0] x0, x1, y0, y1;
  logic signed [17:0] oct_sh;

  assign x0 = $signed({1'b0, fx_r});
  assign y0 = $signed({1'b0, fy_r});
  assign x1 = x0 - 17'sd65536;
  assign y1 = y0 - 17'sd65536;

  // Cell and fraction of the current octave
  assign shx = px_r >> (5'd24 - {1'b0, k_r});
  assign shy = py_r >> (5'd24 - {1'b0, k_r});

  // Fade inner polynomial on the fraction of the current axis
  assign fsel    = (cmd.op == pfn_pkg::OP_O5) ? fy_r : fx_r;
  assign inner_w = 38'd6 * {6'd0, f2_r} + (38'd10 << 32)
                 - ((38'd15 * {22'd0, fsel}) << 16);

  // Select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    diff  = '0;
    case (cmd.op)
      pfn_pkg::OP_PX: begin mul_a = {x_r[31], x_r}; mul_b = {1'b0, bf_r}; end
      pfn_pkg::OP_PY: begin mul_a = {y_r[31], y_r}; mul_b = {1'b0, bf_r}; end
      pfn_pkg::OP_O1: begin mul_a = {17'd0, fx_r}; mul_b = {9'd0, fx_r}; end
      pfn_pkg::OP_O2: begin mul_a = {1'b0, f2_r}; mul_b = {9'd0, fx_r}; end
      pfn_pkg::OP_O3, pfn_pkg::OP_O6: begin
        mul_a = {12'd0, inner_r}; mul_b = {9'd0, t3_r};
      end
      pfn_pkg::OP_O4: begin mul_a = {17'd0, fy_r}; mul_b = {9'd0, fy_r}; end
      pfn_pkg::OP_O5: begin mul_a = {1'b0, f2_r}; mul_b = {9'd0, fy_r}; end
      pfn_pkg::OP_O7: begin
        diff  = {dbr_r[17], dbr_r} - {dbl_r[17], dbl_r};
        mul_a = {{14{diff[18]}}, diff}; mul_b = {8'd0, u_r};
      end
      pfn_pkg::OP_O8: begin
        diff  = {dtr_r[17], dtr_r} - {dtl_r[17], dtl_r};
        mul_a = {{14{diff[18]}}, diff}; mul_b = {8'd0, u_r};
      end
      pfn_pkg::OP_O9: begin
        diff  = {hi_r[17], hi_r} - {lo_r[17], lo_r};
        mul_a = {{14{diff[18]}}, diff}; mul_b = {8'd0, v_r};
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_sh = prod >>> 16;
  assign oct_sh  = noct_r >>> k_r;

  // Permutation read address per step
  always_comb begin
    case (cmd.op)
      pfn_pkg::OP_O1: rd_addr = cx_r;
      pfn_pkg::OP_O2: rd_addr = cx_r + 8'd1;
      pfn_pkg::OP_O3: rd_addr = pa_r + cy_r;
      pfn_pkg::OP_O4: rd_addr = pa_r + cy_r + 8'd1;
      pfn_pkg::OP_O5: rd_addr = pb_r + cy_r;
      pfn_pkg::OP_O6: rd_addr = pb_r + cy_r + 8'd1;
      default:        rd_addr = cx_r;
    endcase
  end

  // Permutation memory: fill after reset, load-mode writes, registered read
  always_ff @(posedge clk) begin
    if (cmd.init_wr) mem[cmd.init_addr] <= pfn_pkg::RESET_PERM[cmd.init_addr];
    else if (cmd.load_wr) mem[tidx_in] <= tval_in;
    rd_r <= mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r <= 5'd4;
      bf_r <= 24'd83886;
    end else if (cfg_we) begin
      if (cfg_index == pfn_pkg::REG_OCTAVE_COUNT) oc_r <= cfg_data[4:0];
      else bf_r <= cfg_data;
    end
  end

  // Octave counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
      k_r <= '0;
    end else if (cmd.start) begin
      n_r <= (oc_r > 5'(pfn_pkg::MAX_OCTAVES)) ? pfn_pkg::CNT_W'(pfn_pkg::MAX_OCTAVES)
                                               : pfn_pkg::CNT_W'(oc_r);
      k_r <= '0;
    end else if (cmd.op == pfn_pkg::OP_O10) begin
      k_r <= k_r + 1'b1;
    end
  end

  assign stat.oct_zero = (n_r == '0);
  assign stat.oct_last = ({1'b0, k_r} + 1'b1 == n_r);

  // Step registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r   <= x_in;
      y_r   <= y_in;
      sum_r <= '0;
    end
    case (cmd.op)
      pfn_pkg::OP_PX: px_r <= prod[55:0];
      pfn_pkg::OP_PY: py_r <= prod[55:0];
      pfn_pkg::OP_O0: begin
        cx_r <= shx[23:16];
        fx_r <= shx[15:0];
        cy_r <= shy[23:16];
        fy_r <= shy[15:0];
      end
      pfn_pkg::OP_O1: f2_r <= prod[31:0];
      pfn_pkg::OP_O2: begin
        t3_r    <= prod[47:32];
        inner_r <= inner_w[36:16];
        pa_r    <= rd_r;
      end
      pfn_pkg::OP_O3: begin
        u_r  <= prod[32:16];
        pb_r <= rd_r;
      end
      pfn_pkg::OP_O4: begin
        f2_r  <= prod[31:0];
        dbl_r <= pfn_pkg::grad_dot(rd_r[2:0], x0, y0);
      end
      pfn_pkg::OP_O5: begin
        t3_r    <= prod[47:32];
        inner_r <= inner_w[36:16];
        dtl_r   <= pfn_pkg::grad_dot(rd_r[2:0], x0, y1);
      end
      pfn_pkg::OP_O6: begin
        v_r   <= prod[32:16];
        dbr_r <= pfn_pkg::grad_dot(rd_r[2:0], x1, y0);
      end
      pfn_pkg::OP_O7: begin
        dtr_r <= pfn_pkg::grad_dot(rd_r[2:0], x1, y1);
        lo_r  <= dbl_r + $signed(prod_sh[17:0]);
      end
      pfn_pkg::OP_O8:  hi_r   <= dtl_r + $signed(prod_sh[17:0]);
      pfn_pkg::OP_O9:  noct_r <= lo_r + $signed(prod_sh[17:0]);
      pfn_pkg::OP_O10: sum_r  <= sum_r + {{6{oct_sh[17]}}, oct_sh};
      default: ;
    endcase
  end

  // Saturate the sum into the output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sum_r > 24'sd524287) out_r <= 20'h7FFFF;
      else if (sum_r < -24'sd524288) out_r <= 20'h80000;
      else out_r <= sum_r[19:0];
    end
  end

  assign noise_value = out_r;

endmodule

### sv/perlin_fbm_noise_2d.sv
// Top level of the fractal 2D gradient-noise generator.
//
//  channel | dir | payload                                   | handshake
//  in_     | in  | tdata x,y,table_index,table_value; tuser mode | tvalid/tready
//  out_    | out | tdata noise_value                         | tvalid/tready
//  cfg_    | in  | index, data (octave_count, base_frequency)| we, no wait
//
// An evaluate beat runs steps PX and PY, an octave pass per capped octave, then
// DONE; each octave is 11 steps of the one shared multiplier and memory port.
// A load beat is written in its accept cycle and the block is ready next cycle.
// After reset the permutation table is filled entry by entry, with in_tready low.
// A waiting result does not block the next accept; a second result waits for it.
module perlin_fbm_noise_2d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // x_coord[31:0], y_coord[63:32], table_index[71:64],
                                 // table_value[79:72]
  input  logic        in_tuser,  // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // noise_value[19:0], zero fill [23:20]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  pfn_pkg::pfn_cmd_t  cmd;
  pfn_pkg::pfn_stat_t stat;
  logic [19:0]        noise_value;

  pfn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pfn_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .x_in        (in_tdata[31:0]),
    .y_in        (in_tdata[63:32]),
    .tidx_in     (in_tdata[71:64]),
    .tval_in     (in_tdata[79:72]),
    .cmd         (cmd),
    .stat        (stat),
    .noise_value (noise_value)
  );

  assign out_tdata = {4'd0, noise_value};

endmodule

### sv/pfn_chk.sv
// Port-level checks for the noise generator, bound to the top level.
module pfn_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // Keep the fill bits zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:20] == 4'd0)
    else $error("result fill bits not zero");

  // Stay not ready while the table fill starts
  a_init_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("ready right after reset");

  // No result appears in the cycle after an accept
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result too early after accept");

endmodule

bind perlin_fbm_noise_2d pfn_chk u_pfn_chk (.*);

### dv/tb.sv
// Self-checking testbench for the fractal 2D gradient-noise generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  DRAIN_CYC = 220;
  localparam int  LONG_HOLD = 400;
  localparam longint LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_data = '0;

  // Model state of the block
  logic [7:0]  perm_copy [pfn_pkg::TABLE_SIZE];
  logic [4:0]  oct_cfg;
  logic [23:0] freq_cfg;
  logic [19:0] noise_q [$];

  int     err_cnt = 0;
  bit     idle_en = 1'b1;
  int     hold_cyc = 0;
  bit     long_hold = 1'b0;
  event   hold_ev;
  longint cyc = 0;

  perlin_fbm_noise_2d dut (.*);

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] perm_at(input logic [7:0] i);
    return perm_copy[i];
  endfunction

  // Quintic fade of a Q0.16 fraction
  function automatic longint fade5(input longint unsigned f);
    longint unsigned inner, t3;
    inner = (6 * f * f + (64'd10 << 32) - ((15 * f) << 16)) >> 16;
    t3 = (f * f * f) >> 32;
    return longint'((t3 * inner) >> 16);
  endfunction

  function automatic longint mix(input longint t, input longint a, input longint b);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic longint grad(input logic [7:0] h, input longint dx, input longint dy);
    case (h[2:0])
      3'd0: return dx + dy;
      3'd1: return dx;
      3'd2: return dx - dy;
      3'd3: return -dy;
      3'd4: return -dx - dy;
      3'd5: return -dx;
      3'd6: return dy - dx;
      default: return dy;
    endcase
  endfunction

  // Expected fBm sum for one point under the current table and registers
  function automatic logic [19:0] exp_noise(input logic [31:0] x, input logic [31:0] y);
    logic [63:0] px, py, sx, sy;
    logic [7:0]  cx, cy, bl, br, tl, tr;
    longint      x0, y0, x1, y1, u, v, lo, hi, sum;
    int          n;
    px = {{32{x[31]}}, x} * {40'd0, freq_cfg};
    py = {{32{y[31]}}, y} * {40'd0, freq_cfg};
    n = (oct_cfg > pfn_pkg::MAX_OCTAVES) ? pfn_pkg::MAX_OCTAVES : oct_cfg;
    sum = 0;
    for (int k = 0; k < n; k++) begin
      sx = px << k;
      sy = py << k;
      cx = sx[47:40];
      cy = sy[47:40];
      x0 = longint'(sx[39:24]);
      y0 = longint'(sy[39:24]);
      x1 = x0 - 65536;
      y1 = y0 - 65536;
      u = fade5(x0);
      v = fade5(y0);
      bl = perm_at(perm_at(cx) + cy);
      br = perm_at(perm_at(cx + 8'd1) + cy);
      tl = perm_at(perm_at(cx) + cy + 8'd1);
      tr = perm_at(perm_at(cx + 8'd1) + cy + 8'd1);
      lo = mix(u, grad(bl, x0, y0), grad(br, x1, y0));
      hi = mix(u, grad(tl, x0, y1), grad(tr, x1, y1));
      sum += mix(v, lo, hi) >>> k;
    end
    if (sum > 524287) sum = 524287;
    if (sum < -524288) sum = -524288;
    return sum[19:0];
  endfunction

  // Send one input beat, with an optional idle burst ahead of it
  task automatic send_beat(input bit mode, input logic [31:0] x, input logic [31:0] y,
                           input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {val, idx, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode) perm_copy[idx] = val;
    else noise_q.push_back(exp_noise(x, y));
  endtask

  task automatic eval_pt(input logic [31:0] x, input logic [31:0] y);
    send_beat(1'b0, x, y, 8'($urandom), 8'($urandom));
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [7:0] val);
    send_beat(1'b1, $urandom, $urandom, idx, val);
  endtask

  // Wait until the block is idle, then write one register
  task automatic write_reg(input logic idx, input logic [23:0] val);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (noise_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == pfn_pkg::REG_OCTAVE_COUNT) oct_cfg = val[4:0];
    else freq_cfg = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0fff_ffff);
      2: return -$urandom_range(0, 32'h0fff_ffff);
      default: return {8'd0, 8'($urandom_range(0, 255)), 16'($urandom)} - 32'h0080_0000;
    endcase
  endfunction

  // Long receiver hold-off, counted here
  always begin
    @(hold_ev);
    long_hold = 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    long_hold = 1'b0;
  end

  // Result side: random stalls, long hold-off on request
  always @(negedge clk) begin
    if (long_hold) begin
      out_tready <= 1'b0;
    end else if (hold_cyc > 0) begin
      out_tready <= 1'b0;
      hold_cyc <= hold_cyc - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      hold_cyc <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expected value
  always @(posedge clk) begin
    logic [19:0] exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      if (noise_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result beat %h", out_tdata[19:0]);
      end else begin
        exp_v = noise_q.pop_front();
        if (out_tdata[19:0] !== exp_v) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("noise_value mismatch: exp %h got %h", exp_v, out_tdata[19:0]);
        end
      end
    end
  end

  // Field extremes under reset settings
  task automatic test_defaults();
    eval_pt(32'h0, 32'h0);
    eval_pt(32'h7fff_ffff, 32'h8000_0000);
    eval_pt(32'h8000_0000, 32'h7fff_ffff);
    eval_pt(32'hffff_ffff, 32'h0001_0000);
    eval_pt(32'h0123_8000, 32'hfedc_4000);
  endtask

  // Octave count and frequency extremes, including capping and zero scale
  task automatic test_settings();
    write_reg(pfn_pkg::REG_OCTAVE_COUNT, 24'd0);
    eval_pt(32'h1234_5678, 32'h9abc_def0);
    write_reg(pfn_pkg::REG_OCTAVE_COUNT, 24'd16);
    write_reg(pfn_pkg::REG_BASE_FREQUENCY, 24'hff_ffff);
    eval_pt(32'h7fff_ffff, 32'h7fff_ffff);
    eval_pt(32'h8000_0000, 32'h8000_0000);
    eval_pt(32'h0000_8000, 32'hffff_8000);
    write_reg(pfn_pkg::REG_OCTAVE_COUNT, 24'd31);
    eval_pt(32'h0003_2100, 32'hfff1_0000);
    write_reg(pfn_pkg::REG_BASE_FREQUENCY, 24'd1);
    eval_pt(32'h7fff_ffff, 32'h8000_0000);
    write_reg(pfn_pkg::REG_BASE_FREQUENCY, 24'd0);
    eval_pt(32'h5555_aaaa, 32'haaaa_5555);
    write_reg(pfn_pkg::REG_OCTAVE_COUNT, 24'd17);
    write_reg(pfn_pkg::REG_BASE_FREQUENCY, 24'h80_0000);
    eval_pt(32'h0100_0000, 32'hff00_0000);
  endtask

  // Permutation writes at the table ends and entry 1, then points that use them
  task automatic test_table_load();
    write_reg(pfn_pkg::REG_OCTAVE_COUNT, 24'd1);
    write_reg(pfn_pkg::REG_BASE_FREQUENCY, 24'h00_0001);
    load_entry(8'd0, 8'd255);
    load_entry(8'd255, 8'd0);
    eval_pt(32'h0000_0000, 32'h0000_0000);
    eval_pt(32'hffff_0000, 32'hffff_0000);
    load_entry(8'd1, 8'd1);
    eval_pt(32'h0080_0000, 32'hff80_0000);
  endtask

  // Random mix of loads and points across several settings
  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(pfn_pkg::REG_OCTAVE_COUNT, (ph == 0) ? 24'd4 : 24'($urandom_range(0, 31)));
      write_reg(pfn_pkg::REG_BASE_FREQUENCY,
                (ph == 1) ? 24'hff_ffff : 24'($urandom_range(1, 24'hff_ffff)));
      for (int i = 0; i < 90; i++) begin
        if (ph == 4 && i == 40) idle_en = 1'b0;
        if ($urandom_range(0, 9) == 0) load_entry(8'($urandom), 8'($urandom));
        else eval_pt(rand_coord(), rand_coord());
      end
    end
  endtask

  // Hold the result side off while the sender keeps offering points
  task automatic test_pressure();
    write_reg(pfn_pkg::REG_OCTAVE_COUNT, 24'd2);
    idle_en = 1'b0;
    @(negedge clk);
    -> hold_ev;
    for (int i = 0; i < 20; i++) eval_pt(rand_coord(), rand_coord());
    idle_en = 1'b1;
    for (int i = 0; i < 60; i++) eval_pt(rand_coord(), rand_coord());
  endtask

  initial begin
    for (int i = 0; i < pfn_pkg::TABLE_SIZE; i++) perm_copy[i] = pfn_pkg::RESET_PERM[i];
    oct_cfg = 5'd4;
    freq_cfg = 24'd83886;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_defaults();
    test_settings();
    test_table_load();
    test_pressure();
    test_random();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (noise_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/pfn_pkg.sv
sv/pfn_ctrl.sv
sv/pfn_dp.sv
sv/perlin_fbm_noise_2d.sv
sv/pfn_chk.sv
dv/tb.sv
